@@ rtl/wft_pkg.sv @@
// Shared types, constants and helpers for the word frequency table
package wft_pkg;

  localparam int MAX_WORD_LEN = 32;
  localparam int TABLE_WORDS  = 256;
  localparam int CW           = $clog2(MAX_WORD_LEN);
  localparam int EW           = $clog2(TABLE_WORDS);
  localparam int SW           = EW + CW;
  localparam int NW           = EW + 1;
  localparam int CNT_W        = 24;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_TEXT  = 2'd0,
    KIND_END   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] text_byte;
    logic [7:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       word_char;
    logic [CNT_W-1:0] word_count;
    logic [8:0]       distinct_words;
    logic             entry_valid;
    logic             table_overflow;
    logic             last_of_run;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SRCH_LEN,
    ST_SRCH_LEN_W,
    ST_SRCH_CHR,
    ST_SRCH_CHR_W,
    ST_APPEND,
    ST_SORT_LEN,
    ST_SORT_LEN_W,
    ST_SORT_LEN_W2,
    ST_SORT_CHR,
    ST_SORT_CHR_A,
    ST_SORT_CHR_B,
    ST_SWAP_RD_A,
    ST_SWAP_RD_B,
    ST_SWAP_WR_A,
    ST_SWAP_WR_B,
    ST_SWAP_META_A,
    ST_SWAP_META_B,
    ST_SORT_NEXT,
    ST_RD_LEN,
    ST_RD_LEN_W,
    ST_RD_CHR,
    ST_RD_CHR_W,
    ST_STATUS
  } state_t;

  function automatic logic is_sep(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d || c == 8'h00 ||
           c == 8'h2e || c == 8'h2c || c == 8'h28 || c == 8'h29 || c == 8'h3b;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
  endfunction

endpackage

@@ rtl/word_frequency_table.sv @@
// Top level of the word frequency table: sequencer, word buffer and tables
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | wft_pkg::in_item_t
//  out_    | output    | out_valid/out_stall | wft_pkg::out_item_t
//
// A text byte is taken while idle. A word end searches over the single store port:
// for each stored entry it reads the length, for each matching character it compares
// a byte, then it bumps the count or appends the word. An end item then bubble sorts,
// reading each pair's meta, comparing characters and swapping characters and meta
// where out of order. A read gives the word one character at a time. in_stall is high
// while the sequencer is busy; out_stall holds the item in the output register.
// Reset is synchronous and clears only control state; the stores need no clearing.
module word_frequency_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wft_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wft_pkg::out_item_t out_data
);
  import wft_pkg::*;

  state_t state_r, state_nxt;

  logic [7:0]       wbuf_r [MAX_WORD_LEN];
  logic [CW-1:0]    wlen_r, wlen_nxt;
  logic [NW-1:0]    ecnt_r, ecnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [NW-1:0]    ent_r, ent_nxt;     // entry under search / sort index j
  logic [NW-1:0]    pass_r, pass_nxt;
  logic [CW-1:0]    ci_r, ci_nxt;       // character index
  logic [CW-1:0]    la_r, la_nxt, lb_r, lb_nxt;
  logic [CNT_W-1:0] ca_r, ca_nxt, cb_r, cb_nxt;
  logic [7:0]       ch_r, ch_nxt;
  logic             sort_r, sort_nxt;   // sort once the open word is closed
  logic [7:0]       idx_r, idx_nxt;
  logic             ovalid_r, ovalid_nxt;
  out_item_t        odata_r, odata_nxt;
  logic             wb_we;
  logic [7:0]       wb_byte;

  // store ports
  logic             s_we;
  logic [SW-1:0]    s_addr;
  logic [7:0]       s_wd, s_rd;
  logic             m_we;
  logic [EW-1:0]    m_addr;
  logic [CW+CNT_W-1:0] m_wd, m_rd;
  logic [CW-1:0]    m_len;
  logic [CNT_W-1:0] m_cnt;

  wft_ram #(.WIDTH(8), .DEPTH(TABLE_WORDS*MAX_WORD_LEN)) u_store (
    .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wd), .rdata(s_rd));
  wft_ram #(.WIDTH(CW+CNT_W), .DEPTH(TABLE_WORDS)) u_meta (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd));

  assign m_len = m_rd[CW+CNT_W-1:CNT_W];
  assign m_cnt = m_rd[CNT_W-1:0];

  logic [EW-1:0] ent_e, ent_e1;
  logic [CW-1:0] min_len, max_len;
  logic          in_acc, out_busy, tbl_full, rd_bad;
  state_t        close_st;
  assign ent_e    = ent_r[EW-1:0];
  assign ent_e1   = ent_e + EW'(1);
  assign min_len  = (la_r < lb_r) ? la_r : lb_r;
  assign max_len  = (la_r < lb_r) ? lb_r : la_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_busy = ovalid_r && out_stall;
  assign tbl_full = (ecnt_r == NW'(TABLE_WORDS));
  assign rd_bad   = (NW'(in_data.entry_index) >= ecnt_r);
  assign close_st = sort_r ? ST_SORT_LEN : ST_IDLE;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  function automatic out_item_t status(input logic [NW-1:0] n, input logic o);
    out_item_t t;
    t.word_char      = '0;
    t.word_count     = '0;
    t.distinct_words = 9'(n);
    t.entry_valid    = 1'b0;
    t.table_overflow = o;
    t.last_of_run    = 1'b1;
    return t;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wlen_r   <= '0;
      ecnt_r   <= '0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wlen_r   <= wlen_nxt;
      ecnt_r   <= ecnt_nxt;
      ovf_r    <= ovf_nxt;
      ovalid_r <= ovalid_nxt;
    end
    if (wb_we) wbuf_r[wlen_r] <= wb_byte;
    ent_r   <= ent_nxt;
    pass_r  <= pass_nxt;
    ci_r    <= ci_nxt;
    la_r    <= la_nxt;
    lb_r    <= lb_nxt;
    ca_r    <= ca_nxt;
    cb_r    <= cb_nxt;
    ch_r    <= ch_nxt;
    sort_r  <= sort_nxt;
    idx_r   <= idx_nxt;
    odata_r <= odata_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (kind_t'(in_data.kind))
            KIND_TEXT:  state_nxt = (is_sep(in_data.text_byte) && wlen_r != '0)
                                    ? ST_SRCH_LEN : ST_IDLE;
            KIND_END:   state_nxt = (wlen_r != '0) ? ST_SRCH_LEN : ST_SORT_LEN;
            KIND_READ:  state_nxt = rd_bad ? ST_STATUS : ST_RD_LEN;
            KIND_CLEAR: state_nxt = ST_STATUS;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SRCH_LEN:    state_nxt = (ent_r >= ecnt_r) ? ST_APPEND : ST_SRCH_LEN_W;
      ST_SRCH_LEN_W:  state_nxt = (m_len == wlen_r) ? ST_SRCH_CHR : ST_SRCH_LEN;
      ST_SRCH_CHR:    state_nxt = (ci_r == wlen_r) ? close_st : ST_SRCH_CHR_W;
      ST_SRCH_CHR_W:  state_nxt = (s_rd == wbuf_r[ci_r]) ? ST_SRCH_CHR : ST_SRCH_LEN;
      ST_APPEND:      state_nxt = (tbl_full || ci_r == wlen_r) ? close_st : ST_APPEND;
      ST_SORT_LEN: begin
        if (pass_r + NW'(1) >= ecnt_r) state_nxt = ST_STATUS;
        else if (ent_r + NW'(1) >= ecnt_r) state_nxt = ST_SORT_NEXT;
        else state_nxt = ST_SORT_LEN_W;
      end
      ST_SORT_LEN_W:  state_nxt = ST_SORT_LEN_W2;
      ST_SORT_LEN_W2: state_nxt = ST_SORT_CHR;
      ST_SORT_CHR:    state_nxt = (ci_r == min_len) ?
                                  ((la_r > lb_r) ? ST_SWAP_RD_A : ST_SORT_LEN) : ST_SORT_CHR_A;
      ST_SORT_CHR_A:  state_nxt = ST_SORT_CHR_B;
      ST_SORT_CHR_B:  state_nxt = (ch_r == s_rd) ? ST_SORT_CHR :
                                  ((ch_r > s_rd) ? ST_SWAP_RD_A : ST_SORT_LEN);
      ST_SWAP_RD_A:   state_nxt = ST_SWAP_RD_B;
      ST_SWAP_RD_B:   state_nxt = ST_SWAP_WR_A;
      ST_SWAP_WR_A:   state_nxt = ST_SWAP_WR_B;
      ST_SWAP_WR_B:   state_nxt = (ci_r + CW'(1) == max_len) ? ST_SWAP_META_A : ST_SWAP_RD_A;
      ST_SWAP_META_A: state_nxt = ST_SWAP_META_B;
      ST_SWAP_META_B: state_nxt = ST_SORT_LEN;
      ST_SORT_NEXT:   state_nxt = ST_SORT_LEN;
      ST_RD_LEN:      state_nxt = ST_RD_LEN_W;
      ST_RD_LEN_W:    state_nxt = ST_RD_CHR;
      ST_RD_CHR:      state_nxt = out_busy ? ST_RD_CHR : ST_RD_CHR_W;
      ST_RD_CHR_W:    state_nxt = (ci_r + CW'(1) == la_r) ? ST_IDLE : ST_RD_CHR;
      ST_STATUS:      state_nxt = out_busy ? ST_STATUS : ST_IDLE;
      default:        state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    wlen_nxt = wlen_r; ecnt_nxt = ecnt_r; ovf_nxt = ovf_r;
    ent_nxt = ent_r; pass_nxt = pass_r; ci_nxt = ci_r;
    la_nxt = la_r; lb_nxt = lb_r; ca_nxt = ca_r; cb_nxt = cb_r; ch_nxt = ch_r;
    sort_nxt = sort_r; idx_nxt = idx_r;
    ovalid_nxt = out_busy;
    odata_nxt = odata_r;
    wb_we = 1'b0; wb_byte = to_lower(in_data.text_byte);
    s_we = 1'b0; s_addr = {ent_e, ci_r}; s_wd = '0;
    m_we = 1'b0; m_addr = ent_e; m_wd = '0;
    case (state_r)
      ST_IDLE: begin
        ent_nxt = '0; ci_nxt = '0; pass_nxt = '0;
        if (in_acc) begin
          case (kind_t'(in_data.kind))
            KIND_TEXT: begin
              sort_nxt = 1'b0;
              if (!is_sep(in_data.text_byte) && wlen_r != CW'(MAX_WORD_LEN-1)) begin
                wb_we = 1'b1; wlen_nxt = wlen_r + CW'(1);
              end
            end
            KIND_END:  sort_nxt = 1'b1;
            KIND_READ: idx_nxt = in_data.entry_index;
            KIND_CLEAR: begin
              ecnt_nxt = '0; ovf_nxt = 1'b0; wlen_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SRCH_LEN: ci_nxt = '0;
      ST_SRCH_LEN_W: begin
        ca_nxt = m_cnt;
        if (m_len != wlen_r) ent_nxt = ent_r + NW'(1);
      end
      ST_SRCH_CHR: begin
        if (ci_r == wlen_r) begin
          m_we = 1'b1;
          m_wd = {wlen_r, (ca_r == COUNT_MAX) ? ca_r : ca_r + CNT_W'(1)};
          wlen_nxt = '0; ent_nxt = '0; pass_nxt = '0;
        end
      end
      ST_SRCH_CHR_W: begin
        if (s_rd == wbuf_r[ci_r]) ci_nxt = ci_r + CW'(1);
        else begin
          ent_nxt = ent_r + NW'(1); ci_nxt = '0;
        end
      end
      // search ended with ent_r at the first free entry
      ST_APPEND: begin
        if (tbl_full) begin
          ovf_nxt = 1'b1; wlen_nxt = '0; ent_nxt = '0; pass_nxt = '0;
        end else if (ci_r == wlen_r) begin
          m_we = 1'b1; m_wd = {wlen_r, CNT_W'(1)};
          ecnt_nxt = ecnt_r + NW'(1);
          wlen_nxt = '0; ent_nxt = '0; pass_nxt = '0;
        end else begin
          s_we = 1'b1; s_wd = wbuf_r[ci_r]; ci_nxt = ci_r + CW'(1);
        end
      end
      // sort: read meta of j then j+1, compare bytes pairwise
      ST_SORT_LEN: ci_nxt = '0;
      ST_SORT_LEN_W: begin
        la_nxt = m_len; ca_nxt = m_cnt; m_addr = ent_e1;
      end
      ST_SORT_LEN_W2: begin
        lb_nxt = m_len; cb_nxt = m_cnt;
      end
      ST_SORT_CHR: begin
        if (ci_r == min_len) begin
          ci_nxt = '0;
          if (!(la_r > lb_r)) ent_nxt = ent_r + NW'(1);
        end
      end
      ST_SORT_CHR_A: begin
        ch_nxt = s_rd; s_addr = {ent_e1, ci_r};
      end
      ST_SORT_CHR_B: begin
        if (ch_r == s_rd) ci_nxt = ci_r + CW'(1);
        else begin
          ci_nxt = '0;
          if (ch_r < s_rd) ent_nxt = ent_r + NW'(1);
        end
      end
      // swap one character: read j, read j+1, write j, write j+1
      ST_SWAP_RD_B: begin
        ch_nxt = s_rd; s_addr = {ent_e1, ci_r};
      end
      ST_SWAP_WR_A: begin
        s_we = 1'b1; s_wd = s_rd;
      end
      ST_SWAP_WR_B: begin
        s_we = 1'b1; s_addr = {ent_e1, ci_r}; s_wd = ch_r;
        ci_nxt = ci_r + CW'(1);
      end
      ST_SWAP_META_A: begin
        m_we = 1'b1; m_wd = {lb_r, cb_r};
      end
      ST_SWAP_META_B: begin
        m_we = 1'b1; m_addr = ent_e1; m_wd = {la_r, ca_r};
        ent_nxt = ent_r + NW'(1);
      end
      ST_SORT_NEXT: begin
        ent_nxt = '0; pass_nxt = pass_r + NW'(1);
      end
      ST_RD_LEN: m_addr = idx_r[EW-1:0];
      ST_RD_LEN_W: begin
        la_nxt = m_len; ca_nxt = m_cnt; ci_nxt = '0;
      end
      ST_RD_CHR: s_addr = {idx_r[EW-1:0], ci_r};
      ST_RD_CHR_W: begin
        ovalid_nxt = 1'b1;
        odata_nxt.word_char = s_rd;
        odata_nxt.word_count = ca_r;
        odata_nxt.distinct_words = 9'(ecnt_r);
        odata_nxt.entry_valid = 1'b1;
        odata_nxt.table_overflow = ovf_r;
        odata_nxt.last_of_run = (ci_r + CW'(1) == la_r);
        ci_nxt = ci_r + CW'(1);
      end
      ST_STATUS: begin
        if (!out_busy) begin
          ovalid_nxt = 1'b1; odata_nxt = status(ecnt_r, ovf_r);
        end
      end
      default: ;
    endcase
  end
endmodule

@@ rtl/wft_ram.sv @@
// Generic single-port RAM with registered read
module wft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
